// ===== sv/sbba_pkg.sv =====
// Shared types, constants and helper functions of the slab bitmap block allocator.
package sbba_pkg;

    // Slab geometry
    localparam int MAX_BLOCKS  = 512;
    localparam int WORD_BITS   = 64;
    localparam int MAP_WORDS   = MAX_BLOCKS / WORD_BITS;
    localparam int WORD_IDX_W  = $clog2(MAP_WORDS);
    localparam int BIT_IDX_W   = $clog2(WORD_BITS);
    localparam int BLK_IDX_W   = $clog2(MAX_BLOCKS);

    // Field widths
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 3;
    localparam int CAP_W       = 10;
    localparam int BSZ_W       = 13;
    localparam int OFF_W       = 16;
    localparam int ADDR_W      = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // Sequencer step counts
    localparam int DIV_STEPS   = ADDR_W;
    localparam int MUL_STEPS   = BLK_IDX_W;
    localparam int CNT_W       = $clog2(DIV_STEPS);
    localparam int AU_W        = ADDR_W + 1;

    // Register reset values
    localparam int CAP_RESET     = 512;
    localparam int CAP_RESET_EFF = (CAP_RESET > MAX_BLOCKS) ? MAX_BLOCKS : CAP_RESET;
    localparam int BSZ_RESET     = 64;
    localparam int OFF_RESET     = 64;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_INIT  = 2'd2
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_BEFORE    = 3'd2,
        ST_MISALIGN  = 3'd3,
        ST_RANGE     = 3'd4,
        ST_DOUBLE    = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPACITY    = 2'd0,
        CFG_BLOCK_BYTES = 2'd1,
        CFG_DATA_OFFSET = 2'd2
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MUL,
        S_OFFS,
        S_DIV,
        S_CHECK,
        S_INIT,
        S_RESP
    } t_state;

    typedef struct packed {
        t_kind              kind;
        logic [ADDR_W-1:0]  free_addr;
    } t_in;

    typedef struct packed {
        t_status            status;
        logic [ADDR_W-1:0]  block_addr;
        logic [CAP_W-1:0]   free_blocks;
        logic               slab_empty;
    } t_out;

    // Bits of map word w that lie below the capacity
    function automatic logic [WORD_BITS-1:0] word_limit(
        input logic [CAP_W-1:0]      cap,
        input logic [WORD_IDX_W-1:0] w
    );
        logic [CAP_W-BIT_IDX_W-1:0] hi;
        logic [BIT_IDX_W-1:0]       lo;
        logic [WORD_BITS-1:0]       m;
        hi = cap[CAP_W-1:BIT_IDX_W];
        lo = cap[BIT_IDX_W-1:0];
        if (hi > (CAP_W-BIT_IDX_W)'(w)) begin
            m = '1;
        end else if (hi == (CAP_W-BIT_IDX_W)'(w)) begin
            m = (WORD_BITS'(1) << lo) - WORD_BITS'(1);
        end else begin
            m = '0;
        end
        return m;
    endfunction

    // Position of the lowest set bit of a map word
    function automatic logic [BIT_IDX_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
        logic [BIT_IDX_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                pos = BIT_IDX_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

// ===== sv/slab_bitmap_block_allocator.sv =====
// Top level of the slab bitmap block allocator: sequencer, shared adder and free bitmap.
//
//  channel | signals                                  | payload
//  --------+------------------------------------------+---------------------------------
//  in      | i_in_valid / o_in_ready, i_in_data       | kind, free_addr
//  out     | o_out_valid / i_out_ready, o_out_data    | status, block_addr, free_blocks,
//          |                                          | slab_empty
//  cfg     | i_cfg_we, i_cfg_idx, i_cfg_data          | capacity, block bytes, data offset
//
// One transaction at a time; the block is ready only in its idle state.
// Allocate: accept, up to 8 word scans, 9 shift-add steps, respond.
// Free: accept, 1 offset subtract, 24 restoring divide steps, 1 check, respond.
// Init: accept, 8 word writes, respond; MUL, OFFS, DIV share a 25-bit add/subtract unit.
// Reset (synchronous) marks every block below the reset capacity free; no clearing pass.
// A finished result waits in the output register; the next transaction is taken meanwhile.
module slab_bitmap_block_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  sbba_pkg::t_in               i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output sbba_pkg::t_out              o_out_data,
    input  logic                        i_cfg_we,
    input  logic [sbba_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sbba_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sbba_pkg::*;

    // State and datapath registers
    t_state                 r_state, n_state;
    logic [WORD_IDX_W-1:0]  r_word, n_word;
    logic [BLK_IDX_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [ADDR_W-1:0]      r_acc, n_acc;
    logic [ADDR_W-1:0]      r_mcand, n_mcand;
    logic [ADDR_W-1:0]      r_quo, n_quo;
    logic [BSZ_W-1:0]       r_part, n_part;
    t_status                r_status, n_status;
    logic [WORD_BITS-1:0]   r_free_map [MAP_WORDS];
    logic [WORD_BITS-1:0]   n_free_map [MAP_WORDS];
    logic [CAP_W-1:0]       r_free_total, n_free_total;
    logic [CAP_W-1:0]       r_cap;
    logic [BSZ_W-1:0]       r_bsz;
    logic [OFF_W-1:0]       r_doff;
    logic                   r_out_valid, n_out_valid;
    t_out                   r_out_data, n_out_data;

    // Derived configuration
    logic [CAP_W-1:0]       cap_eff;
    logic [BSZ_W-1:0]       bsz_eff;

    // Shared add/subtract unit
    logic [AU_W-1:0]        au_a, au_b, au_res;
    logic                   au_sub;

    // Scan and divide helpers
    logic [WORD_BITS-1:0]   scan_word;
    logic [BIT_IDX_W-1:0]   scan_pos;
    logic [BSZ_W:0]         part_sh;
    logic [WORD_BITS-1:0]   chk_word;
    logic [BIT_IDX_W-1:0]   chk_bit;
    logic [WORD_IDX_W-1:0]  chk_wsel;
    logic                   in_fire;
    logic                   out_load;

    assign cap_eff = (r_cap > CAP_W'(MAX_BLOCKS)) ? CAP_W'(MAX_BLOCKS) : r_cap;
    assign bsz_eff = (r_bsz == '0) ? BSZ_W'(1) : r_bsz;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign scan_word = r_free_map[r_word] & word_limit(cap_eff, r_word);
    assign scan_pos  = lowest_set(scan_word);
    assign part_sh   = {r_part, r_quo[ADDR_W-1]};
    assign chk_wsel  = r_quo[BLK_IDX_W-1:BIT_IDX_W];
    assign chk_bit   = r_quo[BIT_IDX_W-1:0];
    assign chk_word  = r_free_map[chk_wsel];

    // Pick the operands of the shared unit for the current step
    always_comb begin
        au_a   = AU_W'(r_acc);
        au_b   = AU_W'(r_mcand);
        au_sub = 1'b0;
        unique case (r_state)
            S_OFFS: begin
                au_a   = AU_W'(r_quo);
                au_b   = AU_W'(r_doff);
                au_sub = 1'b1;
            end
            S_DIV: begin
                au_a   = AU_W'(part_sh);
                au_b   = AU_W'(bsz_eff);
                au_sub = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign au_res = au_sub ? (au_a - au_b) : (au_a + au_b);

    // Sequencer: next state and register updates
    always_comb begin
        n_state      = r_state;
        n_word       = r_word;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_acc        = r_acc;
        n_mcand      = r_mcand;
        n_quo        = r_quo;
        n_part       = r_part;
        n_status     = r_status;
        n_free_map   = r_free_map;
        n_free_total = r_free_total;
        out_load     = 1'b0;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_data   = r_out_data;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_status = ST_OK;
                    n_acc    = '0;
                    n_word   = '0;
                    n_cnt    = '0;
                    unique case (i_in_data.kind)
                        KIND_ALLOC: begin
                            if (r_free_total == '0) begin
                                n_status = ST_FULL;
                                n_state  = S_RESP;
                            end else begin
                                n_state  = S_SCAN;
                            end
                        end
                        KIND_FREE: begin
                            n_quo   = i_in_data.free_addr;
                            n_state = S_OFFS;
                        end
                        KIND_INIT: begin
                            n_state = S_INIT;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end

            // Look at one bitmap word a cycle, lowest first
            S_SCAN: begin
                if (scan_word != '0) begin
                    n_free_map[r_word] = r_free_map[r_word] & ~(WORD_BITS'(1) << scan_pos);
                    n_free_total       = r_free_total - CAP_W'(1);
                    n_idx              = {r_word, scan_pos};
                    n_acc              = ADDR_W'(r_doff);
                    n_mcand            = ADDR_W'(bsz_eff);
                    n_cnt              = '0;
                    n_state            = S_MUL;
                end else if (r_word == WORD_IDX_W'(MAP_WORDS - 1)) begin
                    n_status = ST_FULL;
                    n_state  = S_RESP;
                end else begin
                    n_word = r_word + WORD_IDX_W'(1);
                end
            end

            // Shift-add: accumulate offset + index * block size, one index bit a cycle
            S_MUL: begin
                if (r_idx[0]) begin
                    n_acc = au_res[ADDR_W-1:0];
                end
                n_mcand = r_mcand << 1;
                n_idx   = r_idx >> 1;
                n_cnt   = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                    n_state = S_RESP;
                end
            end

            // Subtract the data offset; a borrow means the address is before the data
            S_OFFS: begin
                if (au_res[AU_W-1]) begin
                    n_status = ST_BEFORE;
                    n_state  = S_RESP;
                end else begin
                    n_quo   = au_res[ADDR_W-1:0];
                    n_part  = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end

            // Restoring division, one quotient bit a cycle
            S_DIV: begin
                if (au_res[AU_W-1]) begin
                    n_part = part_sh[BSZ_W-1:0];
                    n_quo  = {r_quo[ADDR_W-2:0], 1'b0};
                end else begin
                    n_part = au_res[BSZ_W-1:0];
                    n_quo  = {r_quo[ADDR_W-2:0], 1'b1};
                end
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_CHECK;
                end
            end

            // Validate the block index and release the block
            S_CHECK: begin
                n_state = S_RESP;
                if (r_part != '0) begin
                    n_status = ST_MISALIGN;
                end else if (r_quo >= ADDR_W'(cap_eff)) begin
                    n_status = ST_RANGE;
                end else if (chk_word[chk_bit]) begin
                    n_status = ST_DOUBLE;
                end else begin
                    n_free_map[chk_wsel] = chk_word | (WORD_BITS'(1) << chk_bit);
                    n_free_total         = r_free_total + CAP_W'(1);
                end
            end

            // Rewrite the bitmap one word a cycle
            S_INIT: begin
                n_free_map[r_word] = word_limit(cap_eff, r_word);
                if (r_word == WORD_IDX_W'(MAP_WORDS - 1)) begin
                    n_free_total = cap_eff;
                    n_state      = S_RESP;
                end else begin
                    n_word = r_word + WORD_IDX_W'(1);
                end
            end

            // Hand the result to the output register once it is free
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load                = 1'b1;
                    n_out_valid             = 1'b1;
                    n_out_data.status       = r_status;
                    n_out_data.block_addr   = r_acc;
                    n_out_data.free_blocks  = r_free_total;
                    n_out_data.slab_empty   = (r_free_total == cap_eff);
                    n_state                 = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register, bitmap and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_free_total <= CAP_W'(CAP_RESET_EFF);
            r_cap        <= CAP_W'(CAP_RESET);
            r_bsz        <= BSZ_W'(BSZ_RESET);
            r_doff       <= OFF_W'(OFF_RESET);
            for (int w = 0; w < MAP_WORDS; w++) begin
                r_free_map[w] <= word_limit(CAP_W'(CAP_RESET_EFF), WORD_IDX_W'(w));
            end
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_free_total <= n_free_total;
            r_free_map   <= n_free_map;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_CAPACITY:    r_cap  <= i_cfg_data[CAP_W-1:0];
                    CFG_BLOCK_BYTES: r_bsz  <= i_cfg_data[BSZ_W-1:0];
                    CFG_DATA_OFFSET: r_doff <= i_cfg_data[OFF_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_word   <= n_word;
        r_idx    <= n_idx;
        r_cnt    <= n_cnt;
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_quo    <= n_quo;
        r_part   <= n_part;
        r_status <= n_status;
        if (out_load) begin
            r_out_data <= n_out_data;
        end
    end

`ifndef NO_ASSERTIONS
    // The free count never exceeds the number of bitmap bits
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_total <= CAP_W'(MAX_BLOCKS))
        else $error("free count above slab size");

    // A word scan only runs while some block is counted free
    a_scan_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_free_total != '0)
        else $error("scan with zero free count");

    // Dividing leaves the free count alone
    a_div_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |=> $stable(r_free_total))
        else $error("free count moved during divide");

    // Only a successful allocation carries an address
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_OK) |-> o_out_data.block_addr == '0)
        else $error("address on a failed result");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the slab bitmap block allocator: directed and random traffic.
module tb;
    import sbba_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 40;
    localparam int          RANDOM_PHASES  = 14;
    localparam int          PHASE_ITEMS    = 125;
    localparam t_kind       KIND_SPARE     = t_kind'(2'd3);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // Idling modes: percentage of cycles in which a side holds off
    localparam int IDLE_NONE  = 0;
    localparam int IDLE_HEAVY = 76;
    localparam int IDLE_LIGHT = 17;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in                   i_in_data  = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out                  o_out_data;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Requests waiting to be driven and replies predicted for accepted requests
    t_in  alloc_requests[$];
    t_out predicted_replies[$];

    // Predicted slab state and register copies
    logic [WORD_BITS-1:0] pool_map [MAP_WORDS];
    int unsigned          pool_free;
    int unsigned          cfg_cap;
    int unsigned          cfg_bsz;
    int unsigned          cfg_off;

    int          send_idle_pct = IDLE_NONE;
    int          stall_pct     = IDLE_NONE;
    int unsigned error_count   = 0;
    int unsigned quiet_cycles  = 0;

    slab_bitmap_block_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned eff_cap();
        return (cfg_cap > MAX_BLOCKS) ? MAX_BLOCKS : cfg_cap;
    endfunction

    function automatic int unsigned eff_bsz();
        return (cfg_bsz == 0) ? 1 : cfg_bsz;
    endfunction

    // Mark every block below the capacity free, clear the rest
    function automatic void pool_init();
        int unsigned cap;
        int unsigned lo;
        cap = eff_cap();
        for (int w = 0; w < MAP_WORDS; w++) begin
            lo = w * WORD_BITS;
            if (cap >= lo + WORD_BITS) begin
                pool_map[w] = '1;
            end else if (cap > lo) begin
                pool_map[w] = (64'd1 << (cap - lo)) - 64'd1;
            end else begin
                pool_map[w] = '0;
            end
        end
        pool_free = cap;
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input int unsigned idx);
        return ADDR_W'(cfg_off + idx * eff_bsz());
    endfunction

    // Advance the predicted slab by one request and return the reply it gives
    function automatic t_out slab_predict(input t_in req);
        t_out        r;
        int unsigned cap;
        int unsigned bsz;
        int unsigned idx;
        int unsigned off;
        bit          found;
        cap = eff_cap();
        bsz = eff_bsz();
        idx = 0;
        found = 1'b0;
        r = '0;
        r.status = ST_OK;
        case (req.kind)
            KIND_ALLOC: begin
                if (pool_free != 0) begin
                    for (int i = 0; i < cap && !found; i++) begin
                        if (pool_map[i / WORD_BITS][i % WORD_BITS]) begin
                            idx = i;
                            found = 1'b1;
                        end
                    end
                end
                if (found) begin
                    pool_map[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
                    pool_free--;
                    r.block_addr = slot_addr(idx);
                end else begin
                    r.status = ST_FULL;
                end
            end
            KIND_FREE: begin
                if (req.free_addr < cfg_off) begin
                    r.status = ST_BEFORE;
                end else begin
                    off = req.free_addr - cfg_off;
                    idx = off / bsz;
                    if (off % bsz != 0) begin
                        r.status = ST_MISALIGN;
                    end else if (idx >= cap) begin
                        r.status = ST_RANGE;
                    end else if (pool_map[idx / WORD_BITS][idx % WORD_BITS]) begin
                        r.status = ST_DOUBLE;
                    end else begin
                        pool_map[idx / WORD_BITS][idx % WORD_BITS] = 1'b1;
                        pool_free++;
                    end
                end
            end
            KIND_INIT: pool_init();
            default: ;
        endcase
        r.free_blocks = CAP_W'(pool_free);
        r.slab_empty  = (pool_free == cap);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    // Drive one transaction per handshake; predict the reply on acceptance
    always @(posedge i_clk) begin : drive_requests
        t_in  next_req;
        logic next_valid;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            next_valid = i_in_valid;
            next_req   = i_in_data;
            if (i_in_valid && o_in_ready) begin
                predicted_replies.push_back(slab_predict(i_in_data));
                next_valid = 1'b0;
            end
            if (!next_valid && alloc_requests.size() != 0
                && $urandom_range(99) >= send_idle_pct) begin
                next_req   = alloc_requests.pop_front();
                next_valid = 1'b1;
            end
            i_in_valid <= next_valid;
            i_in_data  <= next_req;
        end
    end

    // Check each reply against the oldest prediction; stall at random
    always @(posedge i_clk) begin : check_replies
        t_out want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (predicted_replies.size() == 0) begin
                    report_mismatch("reply with nothing pending", o_out_data.status, 0);
                end else begin
                    want = predicted_replies.pop_front();
                    if (o_out_data.status !== want.status)
                        report_mismatch("status", o_out_data.status, want.status);
                    if (o_out_data.block_addr !== want.block_addr)
                        report_mismatch("block_addr", o_out_data.block_addr, want.block_addr);
                    if (o_out_data.free_blocks !== want.free_blocks)
                        report_mismatch("free_blocks", o_out_data.free_blocks,
                                        want.free_blocks);
                    if (o_out_data.slab_empty !== want.slab_empty)
                        report_mismatch("slab_empty", o_out_data.slab_empty, want.slab_empty);
                end
            end
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // End the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && o_in_ready)
            || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Hold until every request is accepted and every reply has arrived
    task automatic wait_drained();
        do @(negedge i_clk);
        while (alloc_requests.size() != 0 || i_in_valid || predicted_replies.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_CAPACITY:    cfg_cap = data & 16'h03FF;
            CFG_BLOCK_BYTES: cfg_bsz = data & 16'h1FFF;
            CFG_DATA_OFFSET: cfg_off = data;
            default: ;
        endcase
    endtask

    task automatic push_req(input t_kind kind, input logic [ADDR_W-1:0] addr);
        t_in req;
        req.kind      = kind;
        req.free_addr = addr;
        alloc_requests.push_back(req);
    endtask

    // Set random bits above a register's width to check they are dropped
    function automatic logic [CFG_DATA_W-1:0] with_junk(input int unsigned value,
                                                        input int width);
        logic [CFG_DATA_W-1:0] v;
        v = CFG_DATA_W'(value);
        if ($urandom_range(3) == 0)
            v = v | CFG_DATA_W'($urandom << width);
        return v;
    endfunction

    // Build a batch from the current state: mostly allocations and frees of
    // blocks in use, the rest bad addresses, spare kinds and reinitialisation
    task automatic queue_batch(input int n);
        int unsigned in_use[$];
        int unsigned cap;
        int unsigned bsz;
        int unsigned pick;
        int unsigned r;
        t_kind       kind;
        logic [ADDR_W-1:0] addr;
        cap = eff_cap();
        bsz = eff_bsz();
        for (int i = 0; i < cap; i++) begin
            if (!pool_map[i / WORD_BITS][i % WORD_BITS])
                in_use.push_back(i);
        end
        repeat (n) begin
            r    = $urandom_range(99);
            kind = KIND_FREE;
            addr = ADDR_W'($urandom);
            if (r < 45) begin
                kind = KIND_ALLOC;
            end else if (r < 80 && in_use.size() != 0) begin
                pick = $urandom_range(in_use.size() - 1);
                addr = slot_addr(in_use[pick]);
                in_use.delete(pick);
            end else begin
                case ($urandom_range(7))
                    0: if (cap != 0) addr = slot_addr($urandom_range(cap - 1));
                    1: if (bsz > 1)
                           addr = ADDR_W'(slot_addr($urandom_range(cap))
                                          + $urandom_range(bsz - 1, 1));
                    2: if (cfg_off != 0) addr = ADDR_W'($urandom_range(cfg_off - 1));
                    3: addr = slot_addr(cap + $urandom_range(15));
                    4: ;
                    5: kind = KIND_SPARE;
                    6: kind = ($urandom_range(3) == 0) ? KIND_INIT : KIND_ALLOC;
                    default: kind = KIND_ALLOC;
                endcase
            end
            push_req(kind, addr);
        end
    endtask

    initial begin
        int unsigned r;
        int          left;
        int          n;
        cfg_cap = CAP_RESET;
        cfg_bsz = BSZ_RESET;
        cfg_off = OFF_RESET;
        pool_init();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset geometry: every operation and every rejected free
        wait_drained();
        push_req(KIND_ALLOC, '0);
        push_req(KIND_ALLOC, '1);
        push_req(KIND_FREE, 24'd128);
        push_req(KIND_FREE, 24'd128);
        push_req(KIND_FREE, 24'd0);
        push_req(KIND_FREE, 24'd65);
        push_req(KIND_FREE, 24'd64 + 24'd512 * 24'd64);
        push_req(KIND_SPARE, '1);
        push_req(KIND_FREE, '1);
        push_req(KIND_INIT, '0);

        // Shrink capacity without init, zero block size, full slab
        wait_drained();
        write_reg(CFG_CAPACITY, 16'd2);
        write_reg(CFG_BLOCK_BYTES, 16'd0);
        write_reg(CFG_DATA_OFFSET, 16'd0);
        write_reg(CFG_SPARE, 16'hFFFF);
        wait_drained();
        repeat (3) push_req(KIND_ALLOC, '0);
        push_req(KIND_FREE, 24'd1);
        push_req(KIND_FREE, 24'd2);
        push_req(KIND_INIT, '0);
        push_req(KIND_ALLOC, '0);

        // Zero capacity
        wait_drained();
        write_reg(CFG_CAPACITY, 16'd0);
        wait_drained();
        push_req(KIND_INIT, '0);
        push_req(KIND_ALLOC, '0);
        push_req(KIND_FREE, 24'd0);

        // Capacity above the maximum, largest block size and offset
        wait_drained();
        write_reg(CFG_CAPACITY, 16'd1023);
        write_reg(CFG_BLOCK_BYTES, 16'd8191);
        write_reg(CFG_DATA_OFFSET, 16'hFFFF);
        wait_drained();
        push_req(KIND_INIT, '0);
        push_req(KIND_ALLOC, '0);
        push_req(KIND_FREE, 24'd65535);
        push_req(KIND_FREE, 24'd65534);
        push_req(KIND_ALLOC, '0);

        // Random phases over varied geometry and idling
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_drained();
            r = $urandom_range(9);
            if (r < 5)       r = $urandom_range(48, 1);
            else if (r < 7)  r = $urandom_range(512, 49);
            else if (r == 7) r = 512;
            else if (r == 8) r = $urandom_range(1023, 513);
            else             r = 1;
            write_reg(CFG_CAPACITY, with_junk(r, CAP_W));
            r = $urandom_range(5);
            if (r == 0)      r = 0;
            else if (r == 1) r = 1;
            else if (r == 2) r = 8191;
            else if (r == 3) r = 4096;
            else             r = $urandom_range(8191, 1);
            write_reg(CFG_BLOCK_BYTES, with_junk(r, BSZ_W));
            r = $urandom_range(4);
            write_reg(CFG_DATA_OFFSET, (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF
                                                        : 16'($urandom));
            case (p % 4)
                0: begin send_idle_pct = IDLE_NONE;  stall_pct = IDLE_NONE;  end
                1: begin send_idle_pct = IDLE_HEAVY; stall_pct = IDLE_NONE;  end
                2: begin send_idle_pct = IDLE_NONE;  stall_pct = IDLE_HEAVY; end
                default: begin send_idle_pct = IDLE_LIGHT; stall_pct = IDLE_LIGHT; end
            endcase
            wait_drained();
            // Mostly start from a fresh map; sometimes keep the stale one
            if ($urandom_range(99) < 85) begin
                push_req(KIND_INIT, ADDR_W'($urandom));
                wait_drained();
            end
            left = PHASE_ITEMS;
            while (left > 0) begin
                n = $urandom_range(32, 12);
                if (n > left) n = left;
                queue_batch(n);
                left -= n;
                wait_drained();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/sbba_pkg.sv
sv/slab_bitmap_block_allocator.sv
tb/tb.sv
